[rtl/irms_pkg.sv]
// Shared types and constants for the Ising ring Metropolis step block.
`timescale 1ns / 1ps
`default_nettype none
package irms_pkg;

  localparam int unsigned J_W       = 5;
  localparam int unsigned THR_W     = 17;
  localparam int unsigned LEN_W     = 11;
  localparam int unsigned SITE_W    = 10;
  localparam int unsigned RAND_W    = 16;
  localparam int unsigned E_W       = 6;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;

  localparam logic signed [J_W-1:0] COUPLING_RESET  = 5'sd1;
  localparam logic signed [J_W-1:0] COUPLING_MAX    = 5'sd8;
  localparam logic signed [J_W-1:0] COUPLING_MIN    = -5'sd8;
  localparam logic [THR_W-1:0]      THRESHOLD_RESET = 17'd1200;
  localparam logic [LEN_W-1:0]      RING_LEN_RESET  = 11'd1000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUPLING  = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_RING_LEN  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BAD  = 2'd0,
    KIND_LOAD = 2'd1,
    KIND_STEP = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic              spin_value;
    logic [RAND_W-1:0] rand_fraction;
  } req_info_t;

endpackage
`default_nettype wire

[rtl/ising_ring_metropolis_step.sv]
// Top level: configuration registers, front end, item queue and back end.
//
//   channel  signals                                   direction
//   in       in_valid_i / in_ready_o + request fields  item in
//   out      out_valid_o / out_ready_i + result fields item out
//   cfg      cfg_valid_i / cfg_ready_o, index, data    register write
//
// A step item leaves idle through read site, read left, calc and accumulate:
// one spin store read port, so site and neighbors are read in turn. Load and
// out-of-range items finish in idle. The next item is popped only after the
// result is taken. A two-entry queue keeps the input side
// accepting during a stalled result. Reset clears accumulators and control;
// the spin store has no reset value and sites must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module ising_ring_metropolis_step #(
  parameter int unsigned MAX_SITES = 1024
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 req_type_i,
  input  wire logic [irms_pkg::SITE_W-1:0]          site_i,
  input  wire logic                                 spin_value_i,
  input  wire logic [irms_pkg::RAND_W-1:0]          rand_fraction_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic                                      spin_after_o,
  output logic                                      flipped_o,
  output logic signed [irms_pkg::E_W-1:0]           local_energy_o,
  output logic signed [irms_pkg::SUM_W-1:0]         energy_sum_o,
  output logic [irms_pkg::SUM_W-1:0]                energy_sq_sum_o,
  output logic                                      bad_site_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [irms_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [irms_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_SITES);
  localparam int unsigned IW = $bits(irms_pkg::req_info_t);
  localparam int unsigned QW = IW + 3 * AW;

  logic signed [irms_pkg::J_W-1:0] coupling_q;
  logic [irms_pkg::THR_W-1:0]      threshold_q;
  logic [irms_pkg::LEN_W-1:0]      ring_len_q;

  irms_pkg::req_info_t front_info;
  logic [AW-1:0]       front_site;
  logic [AW-1:0]       front_left;
  logic [AW-1:0]       front_right;
  logic [QW-1:0]       push_data;
  logic [QW-1:0]       pop_data;
  logic                pop_valid;
  logic                pop_ready;
  irms_pkg::req_info_t back_info;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q  <= irms_pkg::COUPLING_RESET;
      threshold_q <= irms_pkg::THRESHOLD_RESET;
      ring_len_q  <= irms_pkg::RING_LEN_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        irms_pkg::CFG_COUPLING:  coupling_q  <= cfg_data_i[irms_pkg::J_W-1:0];
        irms_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        irms_pkg::CFG_RING_LEN:  ring_len_q  <= cfg_data_i[irms_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  irms_front #(
    .MAX_SITES(MAX_SITES)
  ) u_front (
    .ring_length_i  (ring_len_q),
    .req_type_i     (req_type_i),
    .site_i         (site_i),
    .spin_value_i   (spin_value_i),
    .rand_fraction_i(rand_fraction_i),
    .info_o         (front_info),
    .site_idx_o     (front_site),
    .left_idx_o     (front_left),
    .right_idx_o    (front_right)
  );

  assign push_data = {front_info, front_site, front_left, front_right};

  irms_queue #(
    .W(QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign back_info = irms_pkg::req_info_t'(pop_data[QW-1:3*AW]);

  irms_back #(
    .MAX_SITES(MAX_SITES)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coupling_i        (coupling_q),
    .accept_threshold_i(threshold_q),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .info_i            (back_info),
    .site_idx_i        (pop_data[3*AW-1:2*AW]),
    .left_idx_i        (pop_data[2*AW-1:AW]),
    .right_idx_i       (pop_data[AW-1:0]),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .spin_after_o      (spin_after_o),
    .flipped_o         (flipped_o),
    .local_energy_o    (local_energy_o),
    .energy_sum_o      (energy_sum_o),
    .energy_sq_sum_o   (energy_sq_sum_o),
    .bad_site_o        (bad_site_o)
  );

endmodule
`default_nettype wire

[rtl/irms_front.sv]
// Front end: range check of the site and neighbor index computation.
`timescale 1ns / 1ps
`default_nettype none
module irms_front #(
  parameter int unsigned MAX_SITES = 1024
) (
  input  wire logic [irms_pkg::LEN_W-1:0]  ring_length_i,
  input  wire logic                        req_type_i,
  input  wire logic [irms_pkg::SITE_W-1:0] site_i,
  input  wire logic                        spin_value_i,
  input  wire logic [irms_pkg::RAND_W-1:0] rand_fraction_i,
  output irms_pkg::req_info_t              info_o,
  output logic [$clog2(MAX_SITES)-1:0]     site_idx_o,
  output logic [$clog2(MAX_SITES)-1:0]     left_idx_o,
  output logic [$clog2(MAX_SITES)-1:0]     right_idx_o
);

  localparam int unsigned AW = $clog2(MAX_SITES);
  localparam int unsigned LW = $clog2(MAX_SITES + 1);
  localparam int unsigned CW = (LW > irms_pkg::LEN_W) ? LW : irms_pkg::LEN_W;

  logic [CW-1:0] ring_ext;
  logic [CW-1:0] len;
  logic [CW-1:0] site_ext;
  logic [CW-1:0] site_p1;
  logic [CW-1:0] left_ext;
  logic [CW-1:0] right_ext;

  always_comb begin
    ring_ext  = CW'(ring_length_i);
    len       = (ring_ext > CW'(MAX_SITES)) ? CW'(MAX_SITES) : ring_ext;
    site_ext  = CW'(site_i);
    site_p1   = site_ext + CW'(1);
    left_ext  = (site_ext == '0) ? (len - CW'(1)) : (site_ext - CW'(1));
    right_ext = (site_p1 == len) ? '0 : site_p1;

    info_o.spin_value    = spin_value_i;
    info_o.rand_fraction = rand_fraction_i;
    if (site_ext >= len) begin
      info_o.kind = irms_pkg::KIND_BAD;
    end else if (req_type_i == irms_pkg::REQ_STEP) begin
      info_o.kind = irms_pkg::KIND_STEP;
    end else begin
      info_o.kind = irms_pkg::KIND_LOAD;
    end

    site_idx_o  = site_ext[AW-1:0];
    left_idx_o  = left_ext[AW-1:0];
    right_idx_o = right_ext[AW-1:0];
  end

endmodule
`default_nettype wire

[rtl/irms_queue.sv]
// Two-entry item queue between the front end and the execution back end.
`timescale 1ns / 1ps
`default_nettype none
module irms_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  wire logic [W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output logic [W-1:0]      pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   count_q;
  logic         push;
  logic         pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

[rtl/irms_back.sv]
// Back end: spin store, Metropolis decision, energy accumulators, result register.
`timescale 1ns / 1ps
`default_nettype none
module irms_back #(
  parameter int unsigned MAX_SITES = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic signed [irms_pkg::J_W-1:0]   coupling_i,
  input  wire logic [irms_pkg::THR_W-1:0]        accept_threshold_i,
  input  wire logic                              pop_valid_i,
  output logic                                   pop_ready_o,
  input  wire irms_pkg::req_info_t               info_i,
  input  wire logic [$clog2(MAX_SITES)-1:0]      site_idx_i,
  input  wire logic [$clog2(MAX_SITES)-1:0]      left_idx_i,
  input  wire logic [$clog2(MAX_SITES)-1:0]      right_idx_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   spin_after_o,
  output logic                                   flipped_o,
  output logic signed [irms_pkg::E_W-1:0]        local_energy_o,
  output logic signed [irms_pkg::SUM_W-1:0]      energy_sum_o,
  output logic [irms_pkg::SUM_W-1:0]             energy_sq_sum_o,
  output logic                                   bad_site_o
);

  localparam int unsigned AW = $clog2(MAX_SITES);
  localparam int unsigned SW = irms_pkg::SUM_W;
  localparam int unsigned EW = irms_pkg::E_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_SITE,
    ST_RD_LEFT,
    ST_CALC,
    ST_ACC
  } state_e;

  state_e                       state_q;
  logic                         mem_q [MAX_SITES];
  logic                         rdata_q;
  logic [AW-1:0]                raddr;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic                         wdata;

  logic [AW-1:0]                site_q;
  logic [AW-1:0]                left_q;
  logic [AW-1:0]                right_q;
  logic [irms_pkg::RAND_W-1:0]  rand_q;
  logic                         s_q;
  logic                         l_q;
  logic                         spin_q;
  logic                         flip_q;
  logic signed [EW-1:0]         energy_q;
  logic                         out_valid_q;
  logic                         out_spin_q;
  logic                         out_flip_q;
  logic signed [EW-1:0]         out_energy_q;
  logic                         out_bad_q;
  logic signed [SW-1:0]         sum_q;
  logic [SW-1:0]                sq_q;

  logic                         pop;
  logic signed [irms_pkg::J_W-1:0] j_sat;
  logic signed [EW-1:0]         two_j;
  logic                         uphill;
  logic                         rand_gt;
  logic                         flip;
  logic                         s_new;
  logic                         l_new;
  logic                         r_new;
  logic signed [EW-1:0]         energy;
  logic signed [2*EW-1:0]       sq_full;
  logic [SW:0]                  sum_wide;
  logic [SW:0]                  sq_wide;

  assign pop_ready_o     = (state_q == ST_IDLE) && !out_valid_q;
  assign pop             = pop_valid_i && pop_ready_o;
  assign out_valid_o     = out_valid_q;
  assign spin_after_o    = out_spin_q;
  assign flipped_o       = out_flip_q;
  assign local_energy_o  = out_energy_q;
  assign bad_site_o      = out_bad_q;
  assign energy_sum_o    = sum_q;
  assign energy_sq_sum_o = sq_q;

  always_comb begin
    unique case (state_q)
      ST_IDLE:    raddr = site_idx_i;
      ST_RD_SITE: raddr = left_q;
      ST_RD_LEFT: raddr = right_q;
      default:    raddr = site_q;
    endcase
  end

  always_comb begin
    if (coupling_i > irms_pkg::COUPLING_MAX) begin
      j_sat = irms_pkg::COUPLING_MAX;
    end else if (coupling_i < irms_pkg::COUPLING_MIN) begin
      j_sat = irms_pkg::COUPLING_MIN;
    end else begin
      j_sat = coupling_i;
    end
    two_j   = {j_sat, 1'b0};
    uphill  = (l_q == rdata_q) && (j_sat != '0) && ((s_q == l_q) != j_sat[irms_pkg::J_W-1]);
    rand_gt = {1'b0, rand_q} > accept_threshold_i;
    flip    = !(uphill && rand_gt);
    s_new   = flip ? ~s_q : s_q;
    l_new   = (left_q == site_q) ? s_new : l_q;
    r_new   = (right_q == site_q) ? s_new : rdata_q;
    if (l_new != r_new) begin
      energy = '0;
    end else if (s_new == l_new) begin
      energy = -two_j;
    end else begin
      energy = two_j;
    end
  end

  always_comb begin
    sq_full  = energy_q * energy_q;
    sum_wide = {sum_q[SW-1], sum_q} + {{(SW + 1 - EW){energy_q[EW-1]}}, energy_q};
    sq_wide  = {1'b0, sq_q} + (SW + 1)'(sq_full[2*EW-2:0]);
  end

  always_comb begin
    we    = 1'b0;
    waddr = site_q;
    wdata = ~s_q;
    if ((state_q == ST_IDLE) && pop && (info_i.kind == irms_pkg::KIND_LOAD)) begin
      we    = 1'b1;
      waddr = site_idx_i;
      wdata = info_i.spin_value;
    end else if ((state_q == ST_CALC) && flip) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_spin_q   <= 1'b0;
      out_flip_q   <= 1'b0;
      out_energy_q <= '0;
      out_bad_q    <= 1'b0;
      sum_q        <= '0;
      sq_q         <= '0;
      site_q       <= '0;
      left_q       <= '0;
      right_q      <= '0;
      rand_q       <= '0;
      s_q          <= 1'b0;
      l_q          <= 1'b0;
      spin_q       <= 1'b0;
      flip_q       <= 1'b0;
      energy_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            site_q  <= site_idx_i;
            left_q  <= left_idx_i;
            right_q <= right_idx_i;
            rand_q  <= info_i.rand_fraction;
            case (info_i.kind)
              irms_pkg::KIND_STEP: begin
                state_q <= ST_RD_SITE;
              end
              irms_pkg::KIND_LOAD: begin
                out_valid_q  <= 1'b1;
                out_spin_q   <= info_i.spin_value;
                out_flip_q   <= 1'b0;
                out_energy_q <= '0;
                out_bad_q    <= 1'b0;
              end
              default: begin
                out_valid_q  <= 1'b1;
                out_spin_q   <= 1'b0;
                out_flip_q   <= 1'b0;
                out_energy_q <= '0;
                out_bad_q    <= 1'b1;
              end
            endcase
          end
        end
        ST_RD_SITE: begin
          s_q     <= rdata_q;
          state_q <= ST_RD_LEFT;
        end
        ST_RD_LEFT: begin
          l_q     <= rdata_q;
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          spin_q   <= s_new;
          flip_q   <= flip;
          energy_q <= energy;
          state_q  <= ST_ACC;
        end
        ST_ACC: begin
          if (sum_wide[SW] != sum_wide[SW-1]) begin
            sum_q <= sum_wide[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
          end else begin
            sum_q <= sum_wide[SW-1:0];
          end
          sq_q         <= sq_wide[SW] ? {SW{1'b1}} : sq_wide[SW-1:0];
          out_valid_q  <= 1'b1;
          out_spin_q   <= spin_q;
          out_flip_q   <= flip_q;
          out_energy_q <= energy_q;
          out_bad_q    <= 1'b0;
          state_q      <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
